// ===== design/rmq_pkg.sv =====
package rmq_pkg;

    localparam int DATA_WIDTH_DEF = 16;
    localparam int FRAC_BITS_DEF = 14;
    localparam int FIFO_DEPTH = 4;

endpackage

// ===== design/rotation_matrix_to_quaternion_unit.sv =====
// rotation matrix to quaternion, signed fixed point: one matrix beat per cycle in and
// one quaternion beat per cycle out while the sink keeps m_axis_tready high; a result
// passes through the bit-per-stage square-root pipeline and the bit-per-stage rounded
// divider that follows it; a non-positive radicand gives zero components with
// bad_radicand set
module rotation_matrix_to_quaternion_unit
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int IW = ((9 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OW = ((4 * DATA_WIDTH + 7) / 8) * 8,
    localparam int RW = DATA_WIDTH + 3,
    localparam int ENTRY_W = 4 * RW + 2
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [IW-1:0] s_axis_tdata,  // r00 r01 r02 r10 r11 r12 r20 r21 r22
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [OW-1:0] m_axis_tdata,  // qx qy qz qw
    output logic          m_axis_tuser   // bad_radicand
);

    logic fv, fr, qv, qr;
    logic [ENTRY_W-1:0] fe, qe;
    logic [4*DATA_WIDTH:0] bd;

    rmq_front #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_data(s_axis_tdata[9*DATA_WIDTH-1:0]),
        .out_valid(fv), .out_ready(fr), .out_entry(fe)
    );

    rmq_fifo #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
        .clk(clk), .rst_n(rst_n),
        .in_valid(fv), .in_ready(fr), .in_data(fe),
        .out_valid(qv), .out_ready(qr), .out_data(qe)
    );

    rmq_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
        .clk(clk), .rst_n(rst_n),
        .in_valid(qv), .in_ready(qr), .in_entry(qe),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(bd)
    );

    assign m_axis_tdata = OW'(bd[4*DATA_WIDTH-1:0]);
    assign m_axis_tuser = bd[4*DATA_WIDTH];

endmodule

// ===== design/rmq_front.sv =====
module rmq_front
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RW = DATA_WIDTH + 3,
    localparam int ENTRY_W = 4 * RW + 2
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [9*DATA_WIDTH-1:0]     in_data,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ENTRY_W-1:0]          out_entry
);

    logic signed [DATA_WIDTH-1:0] e [9];
    logic signed [RW-1:0] xx, yy, zz, xy, yz, zx, yx, zy, xz;
    logic signed [RW-1:0] tr, rad, nx, ny, nz;
    logic neg, zgx, zgy, ygx, fxy, fyz, fzx;
    logic [ENTRY_W-1:0] entry_next, entry_reg;
    logic valid_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            e[i] = in_data[i*DATA_WIDTH +: DATA_WIDTH];
        end
        xx = RW'(e[0]); yx = RW'(e[1]); zx = RW'(e[2]);
        xy = RW'(e[3]); yy = RW'(e[4]); zy = RW'(e[5]);
        xz = RW'(e[6]); yz = RW'(e[7]); zz = RW'(e[8]);
        tr = xx + yy + zz;
        neg = tr[RW-1];
        zgx = zz > xx;
        zgy = zz > yy;
        ygx = yy > xx;
        fxy = neg && (!zgx || !zgy);
        fyz = neg && (ygx || zgx);
        fzx = neg && (zgy || !ygx);
        if (fxy)
        begin
            zz = -zz; xy = -xy;
        end
        if (fyz)
        begin
            xx = -xx; yz = -yz;
        end
        if (fzx)
        begin
            yy = -yy; zx = -zx;
        end
        rad = xx + yy + zz + (RW'(1) <<< FRAC_BITS);
        nx = zy - yz;
        ny = xz - zx;
        nz = yx - xy;
        entry_next = {fyz, fxy, rad, nz, ny, nx};
    end

    assign in_ready = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_entry = entry_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// ===== design/rmq_fifo.sv =====
module rmq_fifo
    import rmq_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = FIFO_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0] cnt_reg;
    logic push, pop;

    assign in_ready = cnt_reg != (AW+1)'(DEPTH);
    assign out_valid = cnt_reg != '0;
    assign out_data = mem_reg[rp_reg];
    assign push = in_valid && in_ready;
    assign pop = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= (wp_reg == AW'(DEPTH-1)) ? '0 : wp_reg + 1'b1;
            end
            if (pop)
            begin
                rp_reg <= (rp_reg == AW'(DEPTH-1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wp_reg] <= in_data;
        end
    end

endmodule

// ===== design/rmq_back.sv =====
module rmq_back
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int RW = DATA_WIDTH + 3,
    localparam int ENTRY_W = 4 * RW + 2,
    localparam int VW = RW + FRAC_BITS,
    localparam int SW = (VW + 1) / 2,
    localparam int NS = SW,
    localparam int MW = RW + FRAC_BITS + 1,
    localparam int DW = MW + 1,
    localparam int QW = MW,
    localparam int PW = 4 * DATA_WIDTH + 1
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ENTRY_W-1:0] in_entry,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [PW-1:0]      out_data
);

    // square root: one result bit per stage; division: one quotient bit per stage
    localparam int LAT = NS + QW + 2;

    typedef struct packed {
        logic             fxy;
        logic             fyz;
        logic             bad;
        logic [3:0]       sgn;
        logic [MW-1:0]    mag3;
        logic [MW-1:0]    mag2;
        logic [MW-1:0]    mag1;
        logic [MW-1:0]    mag0;
    } ctl_t;

    logic adv;
    logic v_reg [LAT];
    ctl_t c_reg [LAT];
    logic [VW-1:0] rem_reg [NS+1];
    logic [SW-1:0] root_reg [NS+1];
    logic [DW-1:0] div_reg [QW+1];
    logic [DW-1:0] r_reg [QW+1][4];
    logic [QW-1:0] q_reg [QW+1][4];
    logic [PW-1:0] out_reg;
    logic ov_reg;

    logic signed [RW-1:0] n [4];
    ctl_t c0;

    assign adv = !ov_reg || out_ready;
    assign in_ready = adv;
    assign out_valid = ov_reg;
    assign out_data = out_reg;

    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            n[k] = in_entry[k*RW +: RW];
        end
        c0.fxy = in_entry[4*RW];
        c0.fyz = in_entry[4*RW+1];
        c0.bad = (n[3] <= 0);
        for (int k = 0; k < 4; k++)
        begin
            c0.sgn[k] = n[k][RW-1];
        end
        c0.mag0 = MW'(n[0][RW-1] ? -n[0] : n[0]) << (FRAC_BITS - 1);
        c0.mag1 = MW'(n[1][RW-1] ? -n[1] : n[1]) << (FRAC_BITS - 1);
        c0.mag2 = MW'(n[2][RW-1] ? -n[2] : n[2]) << (FRAC_BITS - 1);
        c0.mag3 = MW'(n[3][RW-1] ? -n[3] : n[3]) << (FRAC_BITS - 1);
    end

    // square root pipeline
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg[0] <= c0;
            rem_reg[0] <= c0.bad ? '0 : VW'(unsigned'(n[3])) << FRAC_BITS;
            root_reg[0] <= '0;
            for (int i = 0; i < NS; i++)
            begin
                logic [SW+1:0] tr;
                logic [VW-1:0] top;
                tr = {root_reg[i], 2'b01};
                top = rem_reg[i] >> (2 * (NS - 1 - i));
                c_reg[i+1] <= c_reg[i];
                if (top >= VW'(tr))
                begin
                    rem_reg[i+1] <= rem_reg[i] - (VW'(tr) << (2 * (NS - 1 - i)));
                    root_reg[i+1] <= {root_reg[i][SW-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[i+1] <= rem_reg[i];
                    root_reg[i+1] <= {root_reg[i][SW-2:0], 1'b0};
                end
            end
            // rounded divide: q = floor((2*num + s) / (2s))
            div_reg[0] <= DW'(root_reg[NS]) << 1;
            c_reg[NS+1] <= c_reg[NS];
            for (int k = 0; k < 4; k++)
            begin
                logic [MW-1:0] m;
                case (k)
                    0: m = c_reg[NS].mag0;
                    1: m = c_reg[NS].mag1;
                    2: m = c_reg[NS].mag2;
                    3: m = c_reg[NS].mag3;
                    default: m = '0;
                endcase
                r_reg[0][k] <= (DW'(m) << 1) + DW'(root_reg[NS]);
                q_reg[0][k] <= '0;
            end
            for (int j = 0; j < QW; j++)
            begin
                c_reg[NS+2+j] <= c_reg[NS+1+j];
                div_reg[j+1] <= div_reg[j];
                for (int k = 0; k < 4; k++)
                begin
                    logic [DW+QW-1:0] sh;
                    sh = (DW+QW)'(div_reg[j]) << (QW - 1 - j);
                    if ((DW+QW)'(r_reg[j][k]) >= sh)
                    begin
                        r_reg[j+1][k] <= r_reg[j][k] - DW'(sh);
                        q_reg[j+1][k] <= q_reg[j][k] | (QW'(1) << (QW - 1 - j));
                    end
                    else
                    begin
                        r_reg[j+1][k] <= r_reg[j][k];
                        q_reg[j+1][k] <= q_reg[j][k];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LAT; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= in_valid;
            for (int i = 0; i < LAT - 1; i++)
            begin
                v_reg[i+1] <= v_reg[i];
            end
            ov_reg <= v_reg[LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            logic [DATA_WIDTH-1:0] t [4];
            logic [DATA_WIDTH-1:0] p [4];
            ctl_t c;
            c = c_reg[LAT-1];
            for (int k = 0; k < 4; k++)
            begin
                logic [QW-1:0] qv;
                qv = q_reg[QW][k];
                if (c.sgn[k])
                begin
                    t[k] = (qv >= QW'(1) << (DATA_WIDTH - 1))
                        ? {1'b1, {(DATA_WIDTH-1){1'b0}}} : DATA_WIDTH'(-qv);
                end
                else
                begin
                    t[k] = (qv >= QW'(1) << (DATA_WIDTH - 1))
                        ? {1'b0, {(DATA_WIDTH-1){1'b1}}} : DATA_WIDTH'(qv);
                end
                if (c.bad)
                begin
                    t[k] = '0;
                end
            end
            for (int k = 0; k < 4; k++)
            begin
                p[k] = c.fxy ? t[3-k] : t[k];
            end
            out_reg <= c.fyz ? {c.bad, p[2], p[3], p[0], p[1]}
                             : {c.bad, p[3], p[2], p[1], p[0]};
        end
    end

endmodule

// ===== dv/rotation_matrix_to_quaternion_checker.sv =====
module rotation_matrix_to_quaternion_checker
    import rmq_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF,
    localparam int IW = ((9 * DATA_WIDTH + 7) / 8) * 8,
    localparam int OW = ((4 * DATA_WIDTH + 7) / 8) * 8
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    input  logic          s_axis_tready,
    input  logic [IW-1:0] s_axis_tdata,
    input  logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    input  logic [OW-1:0] m_axis_tdata,
    input  logic          m_axis_tuser,
    output int            errors,
    output int            pending,
    output int            quats_seen,
    output int            bad_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_WIDTH-1:0] qw;
        logic [DATA_WIDTH-1:0] qz;
        logic [DATA_WIDTH-1:0] qy;
        logic [DATA_WIDTH-1:0] qx;
        logic                  bad;
    } quat_t;

    quat_t expected_quats[$];

    localparam longint SMAX = (longint'(1) << (DATA_WIDTH - 1)) - 1;

    function automatic longint elem(logic [IW-1:0] d, int i);
        logic signed [DATA_WIDTH-1:0] v;
        v = d[i*DATA_WIDTH +: DATA_WIDTH];
        return longint'(v);
    endfunction

    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v)
            b = b >>> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    function automatic logic [DATA_WIDTH-1:0] half_over_root(longint n, longint s);
        longint mag;
        longint q;
        mag = (n < 0) ? -n : n;
        q = (2 * (mag << (FRAC_BITS - 1)) + s) / (2 * s);
        if (q > SMAX + 1)
            q = SMAX + 1;
        if (n < 0)
            q = -q;
        if (q > SMAX)
            q = SMAX;
        return q[DATA_WIDTH-1:0];
    endfunction

    function automatic quat_t predict_quat(logic [IW-1:0] d);
        longint m[9];
        longint rad;
        longint s;
        logic neg, zgx, zgy, ygx, fxy, fyz, fzx;
        logic [DATA_WIDTH-1:0] t[4];
        logic [DATA_WIDTH-1:0] q[4];
        quat_t r;
        for (int i = 0; i < 9; i++)
            m[i] = elem(d, i);
        neg = (m[0] + m[4] + m[8]) < 0;
        zgx = m[8] > m[0];
        zgy = m[8] > m[4];
        ygx = m[4] > m[0];
        fxy = neg && (!zgx || !zgy);
        fyz = neg && (ygx || zgx);
        fzx = neg && (zgy || !ygx);
        if (fxy)
        begin
            m[8] = -m[8];
            m[3] = -m[3];
        end
        if (fyz)
        begin
            m[0] = -m[0];
            m[7] = -m[7];
        end
        if (fzx)
        begin
            m[4] = -m[4];
            m[2] = -m[2];
        end
        rad = m[0] + m[4] + m[8] + (longint'(1) << FRAC_BITS);
        r = '0;
        if (rad <= 0)
        begin
            r.bad = 1'b1;
            return r;
        end
        s = root_floor(rad << FRAC_BITS);
        t[0] = half_over_root(m[5] - m[7], s);
        t[1] = half_over_root(m[6] - m[2], s);
        t[2] = half_over_root(m[1] - m[3], s);
        t[3] = half_over_root(rad, s);
        for (int i = 0; i < 4; i++)
            q[i] = fxy ? t[3-i] : t[i];
        if (fyz)
        begin
            r.qx = q[1];
            r.qy = q[0];
            r.qz = q[3];
            r.qw = q[2];
        end
        else
        begin
            r.qx = q[0];
            r.qy = q[1];
            r.qz = q[2];
            r.qw = q[3];
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        quat_t e;
        int nerr;
        if (!rst_n)
        begin
            errors <= 0;
            pending <= 0;
            quats_seen <= 0;
            bad_seen <= 0;
        end
        else
        begin
            nerr = 0;
            if (s_axis_tvalid && s_axis_tready)
                expected_quats.push_back(predict_quat(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                quats_seen <= quats_seen + 1;
                if (m_axis_tuser)
                    bad_seen <= bad_seen + 1;
                if (expected_quats.size() == 0)
                begin
                    $error("quaternion beat with nothing expected");
                    nerr++;
                end
                else
                begin
                    e = expected_quats.pop_front();
                    if (m_axis_tdata[0 +: DATA_WIDTH] !== e.qx)
                    begin
                        $error("qx expected %h actual %h", e.qx, m_axis_tdata[0 +: DATA_WIDTH]);
                        nerr++;
                    end
                    if (m_axis_tdata[DATA_WIDTH +: DATA_WIDTH] !== e.qy)
                    begin
                        $error("qy expected %h actual %h", e.qy,
                            m_axis_tdata[DATA_WIDTH +: DATA_WIDTH]);
                        nerr++;
                    end
                    if (m_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH] !== e.qz)
                    begin
                        $error("qz expected %h actual %h", e.qz,
                            m_axis_tdata[2*DATA_WIDTH +: DATA_WIDTH]);
                        nerr++;
                    end
                    if (m_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH] !== e.qw)
                    begin
                        $error("qw expected %h actual %h", e.qw,
                            m_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]);
                        nerr++;
                    end
                    if (m_axis_tuser !== e.bad)
                    begin
                        $error("bad_radicand expected %b actual %b", e.bad, m_axis_tuser);
                        nerr++;
                    end
                end
            end
            errors <= errors + nerr;
            pending <= expected_quats.size();
        end
    end
endmodule

// ===== dv/rotation_matrix_to_quaternion_unit_test.sv =====
module rotation_matrix_to_quaternion_unit_test;
    import rmq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int IW = ((9 * DW + 7) / 8) * 8;
    localparam int OW = ((4 * DW + 7) / 8) * 8;
    localparam int ONE = 1 << FB;
    localparam int RANDOM_BEATS = 930;
    localparam int TAIL_START = 800;
    localparam int LATENCY = (DW + FB) * 2 + 16;
    localparam longint CYCLE_LIMIT = 400000;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [IW-1:0] s_axis_tdata;
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [OW-1:0] m_axis_tdata;
    logic          m_axis_tuser;
    int            errors;
    int            pending;
    int            quats_seen;
    int            bad_seen;
    longint        cycles = 0;
    int            beats_sent;
    bit            quiet_tail;
    bit            hold_sink;

    rotation_matrix_to_quaternion_unit uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    rotation_matrix_to_quaternion_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .errors(errors), .pending(pending), .quats_seen(quats_seen), .bad_seen(bad_seen)
    );

    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // sink side: random stalls, one long hold-off, none in the tail
    initial
    begin
        int gap;
        m_axis_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_sink)
            begin
                m_axis_tready <= 1'b0;
                repeat (200) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 15);
                m_axis_tready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    function automatic logic [IW-1:0] pack_matrix(logic [DW-1:0] m[9]);
        logic [IW-1:0] d;
        d = '0;
        for (int i = 0; i < 9; i++)
            d[i*DW +: DW] = m[i];
        return d;
    endfunction

    task automatic send_beat(logic [IW-1:0] d);
        int gap;
        if (!quiet_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= d;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        beats_sent++;
    endtask

    task automatic send_matrix(logic [DW-1:0] m[9]);
        send_beat(pack_matrix(m));
    endtask

    function automatic logic [DW-1:0] near(int v, int spread);
        int r;
        r = v + $urandom_range(0, 2 * spread) - spread;
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[DW-1:0];
    endfunction

    // a rotation-like matrix: signed permutation with noise, so every branch is hit
    task automatic send_rotation_like();
        logic [DW-1:0] m[9];
        int perm[3];
        int sgn;
        int spread;
        perm = '{0, 1, 2};
        perm.shuffle();
        spread = $urandom_range(0, 1) ? 300 : 6000;
        for (int i = 0; i < 9; i++)
            m[i] = near(0, spread);
        for (int r = 0; r < 3; r++)
        begin
            sgn = $urandom_range(0, 1) ? ONE : -ONE;
            m[r*3 + perm[r]] = near(sgn, spread);
        end
        send_matrix(m);
    endtask

    task automatic send_noise();
        logic [DW-1:0] m[9];
        for (int i = 0; i < 9; i++)
            m[i] = DW'($urandom());
        send_matrix(m);
    endtask

    task automatic send_uniform(int v);
        logic [DW-1:0] m[9];
        for (int i = 0; i < 9; i++)
            m[i] = v[DW-1:0];
        send_matrix(m);
    endtask

    task automatic send_diag(int a, int b, int c);
        logic [DW-1:0] m[9];
        for (int i = 0; i < 9; i++)
            m[i] = '0;
        m[0] = a[DW-1:0];
        m[4] = b[DW-1:0];
        m[8] = c[DW-1:0];
        send_matrix(m);
    endtask

    initial
    begin
        beats_sent = 0;
        quiet_tail = 1'b0;
        hold_sink = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // identity and half-turns about each axis
        send_diag(ONE, ONE, ONE);
        send_diag(ONE, -ONE, -ONE);
        send_diag(-ONE, ONE, -ONE);
        send_diag(-ONE, -ONE, ONE);
        // negative trace with tied diagonal entries
        send_diag(-ONE / 3, -ONE / 3, -ONE / 3 - 1);
        send_diag(-ONE, -ONE, -ONE);
        send_diag(0, 0, -ONE);
        send_diag(-32768, -32768, -32768);
        // extremes and saturation
        send_uniform(32767);
        send_uniform(-32768);
        send_uniform(0);
        send_uniform(-1);
        send_uniform(1);
        send_diag(-ONE + 1, -ONE + 1, -ONE + 1);
        send_diag(32767, -32768, -32768);
        send_diag(-32768, 32767, -32768);
        send_diag(-32768, -32768, 32767);
        send_diag(0, 0, 0);
        send_diag(-1, 0, 0);
        for (int i = 0; i < 4; i++)
            send_noise();

        // hold the sink off long enough that the block backs up into its input
        hold_sink = 1'b1;
        for (int i = 0; i < 30; i++)
            send_rotation_like();

        for (int i = 0; i < RANDOM_BEATS; i++)
        begin
            if (i == 400)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
            end
            if (i == TAIL_START)
                quiet_tail = 1'b1;
            if ($urandom_range(0, 4) == 0)
                send_noise();
            else
                send_rotation_like();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge clk);

        while (pending != 0 || hold_sink)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);

        $display("sent %0d matrices, checked %0d quaternions, %0d with a bad radicand",
            beats_sent, quats_seen, bad_seen);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
